// ===== design/macc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average crossover counter package
// Shared sizes, codes, types and the window clamp used by the counter unit.
// ----------------------------------------------------------------------------
package macc_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 16;

   localparam int PTR_BITS   = $clog2(MAX_WINDOW);
   localparam int FILL_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS   = SAMPLE_BITS + PTR_BITS;
   localparam int PROD_BITS  = SUM_BITS + FILL_BITS + 1;
   localparam int WIN_BITS   = 7;
   localparam int COUNT_BITS = 16;
   localparam int DIR_BITS   = 2;
   localparam int ADDR_BITS  = 3;
   localparam int DATA_BITS  = 32;

   localparam logic [DIR_BITS-1:0] DIR_UNKNOWN = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_ABOVE   = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_BELOW   = 2'd2;

   localparam logic [ADDR_BITS-1:0] ADDR_SHORT = 3'd0;
   localparam logic [ADDR_BITS-1:0] ADDR_LONG  = 3'd4;

   localparam logic [WIN_BITS-1:0]   SHORT_RESET = 7'd4;
   localparam logic [WIN_BITS-1:0]   LONG_RESET  = 7'd16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic [FILL_BITS-1:0]          win_type;

   typedef struct packed {
      logic    enough;
      sum_type short_sum;
      sum_type long_sum;
   } win_sums_type;

   function automatic win_type clamp_window(input logic [WIN_BITS-1:0] raw);
      win_type result;
      if (raw == '0) begin
         result = win_type'(1);
      end else if (int'(raw) > MAX_WINDOW) begin
         result = win_type'(MAX_WINDOW);
      end else begin
         result = win_type'(raw);
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// ===== design/macc_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average window stage
// Holds the sample history and updates the short and long running sums.
// ----------------------------------------------------------------------------
module macc_window (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  restart,
   input  wire logic                  accept,
   input  wire logic                  advance,
   input  wire macc_pkg::sample_type  sample,
   input  wire macc_pkg::win_type     short_win,
   input  wire macc_pkg::win_type     long_win,
   output macc_pkg::win_sums_type     sums
);
   import macc_pkg::*;

   sample_type                hist [MAX_WINDOW];
   logic [PTR_BITS-1:0]       wp_ff, wp_in;
   win_type                   fill_ff, fill_in;
   win_type                   need;
   logic [PTR_BITS-1:0]       addr_s, addr_l;
   sample_type                x_ff, rd_s_ff, rd_l_ff;
   logic                      sub_s_ff, sub_l_ff, ok_a_ff;
   sum_type                   short_ff, short_in, long_ff, long_in;
   logic                      ok_b_ff;

   function automatic logic [PTR_BITS-1:0] ring_back(input logic [PTR_BITS-1:0] ptr,
                                                     input win_type win);
      logic [FILL_BITS:0] pos;
      pos = (FILL_BITS + 1)'(ptr);
      if (pos < (FILL_BITS + 1)'(win)) begin
         pos = pos + (FILL_BITS + 1)'(MAX_WINDOW);
      end
      pos = pos - (FILL_BITS + 1)'(win);
      return pos[PTR_BITS-1:0];
   endfunction

   assign need    = (short_win > long_win) ? short_win : long_win;
   assign addr_s  = ring_back(wp_ff, short_win);
   assign addr_l  = ring_back(wp_ff, long_win);
   assign wp_in   = (int'(wp_ff) == MAX_WINDOW - 1) ? '0 : wp_ff + 1'b1;
   assign fill_in = (int'(fill_ff) < MAX_WINDOW) ? fill_ff + 1'b1 : fill_ff;

   assign short_in = short_ff - (sub_s_ff ? SUM_BITS'(rd_s_ff) : '0) + SUM_BITS'(x_ff);
   assign long_in  = long_ff - (sub_l_ff ? SUM_BITS'(rd_l_ff) : '0) + SUM_BITS'(x_ff);

   // The history read returns the old entry when its address is also written.
   always_ff @(posedge clock) begin
      if (accept) begin
         hist[wp_ff] <= sample;
         rd_s_ff     <= hist[addr_s];
         rd_l_ff     <= hist[addr_l];
         x_ff        <= sample;
         sub_s_ff    <= fill_ff >= short_win;
         sub_l_ff    <= fill_ff >= long_win;
         ok_a_ff     <= fill_in >= need;
      end
      if (advance) begin
         ok_b_ff <= ok_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         wp_ff    <= '0;
         fill_ff  <= '0;
         short_ff <= '0;
         long_ff  <= '0;
      end else begin
         if (accept) begin
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
         end
         if (advance) begin
            short_ff <= short_in;
            long_ff  <= long_in;
         end
      end
   end

   assign sums.enough    = ok_b_ff;
   assign sums.short_sum = short_ff;
   assign sums.long_sum  = long_ff;

endmodule
`default_nettype wire

// ===== design/moving_average_crossover_counter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average crossover counter unit
// Tracks a short and a long moving average of a sample stream and counts
// the times the short average crosses the long one.
// ----------------------------------------------------------------------------
// The unit takes one sample request per clock while the result side does
// not stall, and returns one result per request, in order. The four stages
// are the history read, the running sum update, the two cross products,
// and the compare with the crossing counter; a stall on the result side
// fills the empty stages before it reaches the request side. Writing either
// window register restarts the averaging and keeps the crossing count;
// write it only while no request is in flight.
module moving_average_crossover_counter_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire macc_pkg::sample_type                 req_sample,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_averages_valid,
   output logic                                      rsp_crossed,
   output logic [macc_pkg::DIR_BITS-1:0]             rsp_direction,
   output logic [macc_pkg::COUNT_BITS-1:0]           rsp_cross_count,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [macc_pkg::ADDR_BITS-1:0]       paddr,
   input  wire logic [macc_pkg::DATA_BITS-1:0]       pwdata,
   output logic [macc_pkg::DATA_BITS-1:0]            prdata,
   output logic                                      pready
);
   import macc_pkg::*;

   logic [WIN_BITS-1:0]   short_cfg_ff, long_cfg_ff;
   win_type               short_win, long_win;
   logic                  cfg_write, restart;

   logic                  va_ff, vb_ff, vc_ff;
   logic                  load_a, load_b, load_c, load_d;
   logic                  accept, move_ab, move_bc, move_cd;

   win_sums_type          sums;
   logic signed [FILL_BITS:0]    short_s, long_s;
   logic signed [PROD_BITS-1:0]  lhs_ff, rhs_ff;
   logic                  ok_c_ff;

   logic                  crossed_in;
   logic [DIR_BITS-1:0]   trend_ff, trend_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign restart   = cfg_write && (paddr == ADDR_SHORT || paddr == ADDR_LONG);

   always_ff @(posedge clock) begin
      if (reset) begin
         short_cfg_ff <= SHORT_RESET;
         long_cfg_ff  <= LONG_RESET;
      end else if (cfg_write) begin
         case (paddr)
            ADDR_SHORT: short_cfg_ff <= pwdata[WIN_BITS-1:0];
            ADDR_LONG:  long_cfg_ff  <= pwdata[WIN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr)
         ADDR_SHORT: prdata = DATA_BITS'(short_cfg_ff);
         ADDR_LONG:  prdata = DATA_BITS'(long_cfg_ff);
         default:    prdata = '0;
      endcase
   end

   assign short_win = clamp_window(short_cfg_ff);
   assign long_win  = clamp_window(long_cfg_ff);

   assign load_d    = !rsp_valid || !rsp_stall;
   assign load_c    = !vc_ff || load_d;
   assign load_b    = !vb_ff || load_c;
   assign load_a    = !va_ff || load_b;
   assign req_stall = !load_a;
   assign accept    = req_valid && load_a;
   assign move_ab   = va_ff && load_b;
   assign move_bc   = vb_ff && load_c;
   assign move_cd   = vc_ff && load_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff     <= 1'b0;
         vb_ff     <= 1'b0;
         vc_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (load_a) begin
            va_ff <= req_valid;
         end
         if (load_b) begin
            vb_ff <= va_ff;
         end
         if (load_c) begin
            vc_ff <= vb_ff;
         end
         if (load_d) begin
            rsp_valid <= vc_ff;
         end
      end
   end

   macc_window u_window (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .accept    (accept),
      .advance   (move_ab),
      .sample    (req_sample),
      .short_win (short_win),
      .long_win  (long_win),
      .sums      (sums)
   );

   assign short_s = $signed({1'b0, short_win});
   assign long_s  = $signed({1'b0, long_win});

   always_ff @(posedge clock) begin
      if (move_bc) begin
         lhs_ff  <= PROD_BITS'(sums.short_sum) * PROD_BITS'(long_s);
         rhs_ff  <= PROD_BITS'(sums.long_sum) * PROD_BITS'(short_s);
         ok_c_ff <= sums.enough;
      end
   end

   always_comb begin
      crossed_in = 1'b0;
      trend_in   = trend_ff;
      if (ok_c_ff) begin
         if (lhs_ff > rhs_ff) begin
            crossed_in = (trend_ff == DIR_BELOW);
            trend_in   = DIR_ABOVE;
         end else if (lhs_ff < rhs_ff) begin
            crossed_in = (trend_ff == DIR_ABOVE);
            trend_in   = DIR_BELOW;
         end
      end
      count_in = (crossed_in && count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trend_ff <= DIR_UNKNOWN;
         count_ff <= '0;
      end else if (restart) begin
         trend_ff <= DIR_UNKNOWN;
      end else if (move_cd) begin
         trend_ff <= trend_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move_cd) begin
         rsp_averages_valid <= ok_c_ff;
         rsp_crossed        <= crossed_in;
         rsp_direction      <= ok_c_ff ? trend_in : DIR_UNKNOWN;
      end
   end

   assign rsp_cross_count = count_ff;

   a_cross_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crossed |-> rsp_averages_valid && rsp_direction != DIR_UNKNOWN)
      else $error("crossing reported without a known direction");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff >= $past(count_ff))
      else $error("crossing count decreased");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && count_ff != $past(count_ff) |-> $past(move_cd) && $past(crossed_in))
      else $error("crossing count changed without a crossing");

endmodule
`default_nettype wire
